[design/dar_pkg.sv]
// Shared types and constants for the DNS A-record responder.
// No dependencies; imported by the front, queue, back and top-level modules.
`default_nettype none

package dar_pkg;

   // Default sizing
   localparam int MaxPacketDef  = 512;
   localparam int QueueDepthDef = 4;

   // Command kinds passed from the front to the back
   localparam logic [1:0] KIND_BYTE = 2'd0;  // one response byte
   localparam logic [1:0] KIND_MARK = 2'd1;  // bare end marker
   localparam logic [1:0] KIND_HDR  = 2'd2;  // twelve header bytes
   localparam logic [1:0] KIND_ANS  = 2'd3;  // last QCLASS byte plus the A record

   // Status codes reported on the final result of a packet
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_SHORT = 2'd1;
   localparam logic [1:0] ST_TRUNC = 2'd2;

   // One queued command; hdr[0] is the first header byte
   typedef struct packed {
      logic [1:0]       kind;
      logic [7:0]       data;
      logic             last;
      logic [1:0]       status;
      logic [15:0]      qtype;
      logic [11:0][7:0] hdr;
   } dar_cmd_type;

endpackage

`default_nettype wire

[design/dar_front.sv]
// Front end: accepts query bytes, tracks header and question parsing,
// and issues one command per byte that causes results. Uses dar_pkg.
`default_nettype none

module dar_front
   import dar_pkg::*;
#(
   parameter int MAX_PACKET = MaxPacketDef
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        accept,
   input  wire logic [7:0]  in_byte,
   input  wire logic        in_last,
   output dar_cmd_type      cmd,
   output logic             push
);

   localparam int PosW = $clog2(MAX_PACKET + 1);
   localparam logic [PosW-1:0] POS_MAX   = PosW'(MAX_PACKET);
   localparam logic [PosW-1:0] POS_LIMIT = PosW'(MAX_PACKET - 18);
   localparam logic [PosW-1:0] POS_HDR_END = PosW'(11);
   localparam logic [PosW-1:0] POS_HDR_LEN = PosW'(12);

   // Parse phases
   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_LEN  = 3'd1;
   localparam logic [2:0] PH_BODY = 3'd2;
   localparam logic [2:0] PH_PTR  = 3'd3;
   localparam logic [2:0] PH_TAIL = 3'd4;
   localparam logic [2:0] PH_DROP = 3'd5;

   logic [7:0]      hold_ff [12];
   logic [PosW-1:0] pos_ff, pos_in;
   logic [2:0]      phase_ff, phase_in;
   logic [7:0]      remain_ff, remain_in;
   logic [2:0]      tail_ff, tail_in;
   logic [15:0]     qtype_ff, qtype_in;

   logic            has_q;
   logic [2:0]      tail_next;
   logic [15:0]     qtype_next;

   assign has_q = (hold_ff[4] | hold_ff[5]) != 8'h00;
   assign tail_next = tail_ff + 3'd1;

   // Capture QTYPE from the first two tail bytes
   always_comb begin
      case (tail_ff)
         3'd0:    qtype_next = {in_byte, 8'h00};
         3'd1:    qtype_next = {qtype_ff[15:8], in_byte};
         default: qtype_next = qtype_ff;
      endcase
   end

   // Build the response header from the held bytes and the current byte
   always_comb begin
      cmd = '0;
      for (int i = 0; i < 11; i++) begin
         cmd.hdr[i] = hold_ff[i];
      end
      cmd.hdr[2]  = hold_ff[2] | 8'h80;
      cmd.hdr[3]  = hold_ff[3] & 8'hF0;
      cmd.hdr[6]  = 8'h00;
      cmd.hdr[7]  = 8'h01;
      cmd.hdr[11] = in_byte;
      cmd.data    = in_byte;

      push      = 1'b0;
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      remain_in = remain_ff;
      tail_in   = tail_ff;
      qtype_in  = qtype_ff;

      if (accept) begin
         if (phase_ff == PH_IDLE) begin
            if (pos_ff == POS_HDR_END) begin
               push     = 1'b1;
               cmd.kind = KIND_HDR;
               cmd.last = !has_q || in_last;
               cmd.status = ST_OK;
               phase_in = (!has_q || in_last) ? PH_DROP : PH_LEN;
            end else if (in_last) begin
               push       = 1'b1;
               cmd.kind   = KIND_MARK;
               cmd.last   = 1'b1;
               cmd.status = ST_SHORT;
            end
         end else if (phase_ff != PH_DROP) begin
            if (pos_ff > POS_LIMIT) begin
               // Answer would not fit: end with a marker, drop the rest
               push       = 1'b1;
               cmd.kind   = KIND_MARK;
               cmd.last   = 1'b1;
               cmd.status = ST_TRUNC;
               phase_in   = PH_DROP;
            end else begin
               push       = 1'b1;
               cmd.kind   = KIND_BYTE;
               cmd.last   = in_last;
               cmd.status = in_last ? ST_TRUNC : ST_OK;
               unique case (phase_ff)
                  PH_LEN: begin
                     if (in_byte == 8'h00) begin
                        phase_in = PH_TAIL;
                        tail_in  = 3'd0;
                     end else if ((in_byte & 8'hC0) == 8'hC0) begin
                        phase_in = PH_PTR;
                     end else begin
                        remain_in = in_byte;
                        phase_in  = PH_BODY;
                     end
                  end
                  PH_BODY: begin
                     remain_in = remain_ff - 8'd1;
                     if (remain_in == 8'd0) begin
                        phase_in = PH_LEN;
                     end
                  end
                  PH_PTR: begin
                     phase_in = PH_TAIL;
                     tail_in  = 3'd0;
                  end
                  PH_TAIL: begin
                     qtype_in = qtype_next;
                     tail_in  = tail_next;
                     if (tail_next >= 3'd4) begin
                        cmd.kind   = KIND_ANS;
                        cmd.last   = 1'b1;
                        cmd.status = ST_OK;
                        cmd.qtype  = qtype_next;
                        phase_in   = PH_DROP;
                     end else if (in_last && tail_next >= 3'd2) begin
                        cmd.qtype = qtype_next;
                     end
                  end
                  default: begin
                     push     = 1'b0;
                     phase_in = PH_DROP;
                  end
               endcase
            end
         end

         // End of packet clears parse state; otherwise advance the position
         if (in_last) begin
            pos_in    = '0;
            phase_in  = PH_IDLE;
            remain_in = 8'd0;
            tail_in   = 3'd0;
            qtype_in  = 16'd0;
         end else if (pos_ff != POS_MAX) begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         phase_ff  <= PH_IDLE;
         remain_ff <= 8'd0;
         tail_ff   <= 3'd0;
         qtype_ff  <= 16'd0;
      end else begin
         pos_ff    <= pos_in;
         phase_ff  <= phase_in;
         remain_ff <= remain_in;
         tail_ff   <= tail_in;
         qtype_ff  <= qtype_in;
      end
   end

   // Hold the header bytes as they arrive
   always_ff @(posedge clock) begin
      if (accept && phase_ff == PH_IDLE && pos_ff < POS_HDR_LEN) begin
         hold_ff[pos_ff[3:0]] <= in_byte;
      end
   end

endmodule

`default_nettype wire

[design/dar_queue.sv]
// Short command queue between the front and back ends.
// Uses dar_pkg for the command type.
`default_nettype none

module dar_queue
   import dar_pkg::*;
#(
   parameter int DEPTH = QueueDepthDef
) (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  push,
   input  dar_cmd_type push_data,
   input  wire logic  pop,
   output dar_cmd_type head,
   output logic       not_empty,
   output logic       full
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] PTR_LAST = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] CNT_FULL = CntW'(DEPTH);

   dar_cmd_type      slot_ff [DEPTH];
   logic [PtrW-1:0]  wr_ff, wr_in;
   logic [PtrW-1:0]  rd_ff, rd_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign not_empty = (cnt_ff != '0);
   assign full      = (cnt_ff == CNT_FULL);
   assign head      = slot_ff[rd_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // Advance pointers and occupancy
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_LAST) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_LAST) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Store the incoming command
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[design/dar_back.sv]
// Back end: expands queued commands into response bytes, one per cycle while
// rsp_stall is low, through a registered output stage. Uses dar_pkg.
`default_nettype none

module dar_back
   import dar_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  dar_cmd_type      head,
   input  wire logic        head_valid,
   output logic             pop,
   input  wire logic [31:0] answer_ipv4,
   input  wire logic [31:0] answer_ttl,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_out_valid,
   output logic             rsp_out_last,
   output logic [1:0]       rsp_status,
   output logic [15:0]      rsp_qtype
);

   // Fixed A record: pointer, type, class, TTL, length, address
   function automatic logic [7:0] answer_byte(input logic [3:0] idx,
                                              input logic [31:0] ttl,
                                              input logic [31:0] ip);
      logic [7:0] b;
      case (idx)
         4'd0:    b = 8'hC0;
         4'd1:    b = 8'h0C;
         4'd2:    b = 8'h00;
         4'd3:    b = 8'h01;
         4'd4:    b = 8'h00;
         4'd5:    b = 8'h01;
         4'd6:    b = ttl[31:24];
         4'd7:    b = ttl[23:16];
         4'd8:    b = ttl[15:8];
         4'd9:    b = ttl[7:0];
         4'd10:   b = 8'h00;
         4'd11:   b = 8'h04;
         4'd12:   b = ip[31:24];
         4'd13:   b = ip[23:16];
         4'd14:   b = ip[15:8];
         default: b = ip[7:0];
      endcase
      return b;
   endfunction

   dar_cmd_type cur_ff, cur_in;
   logic        busy_ff, busy_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        bvalid_ff, bvalid_in;
   logic        last_ff, last_in;
   logic [1:0]  status_ff, status_in;
   logic [15:0] qtype_ff, qtype_in;

   logic        load;
   logic        final_beat;
   logic [4:0]  last_idx;
   logic [3:0]  ans_idx;

   assign load    = busy_ff && (!valid_ff || !rsp_stall);
   assign ans_idx = 4'(cnt_ff - 5'd1);

   // Index of the final beat of the current command
   always_comb begin
      case (cur_ff.kind)
         KIND_HDR: last_idx = 5'd11;
         KIND_ANS: last_idx = 5'd16;
         default:  last_idx = 5'd0;
      endcase
   end

   assign final_beat = (cnt_ff == last_idx);
   assign pop = head_valid && (!busy_ff || (load && final_beat));

   // Form the result for the current beat
   always_comb begin
      byte_in   = cur_ff.data;
      bvalid_in = 1'b1;
      last_in   = 1'b0;
      status_in = ST_OK;
      qtype_in  = 16'd0;
      case (cur_ff.kind)
         KIND_BYTE: begin
            last_in   = cur_ff.last;
            status_in = cur_ff.status;
            qtype_in  = cur_ff.qtype;
         end
         KIND_MARK: begin
            byte_in   = 8'h00;
            bvalid_in = 1'b0;
            last_in   = 1'b1;
            status_in = cur_ff.status;
         end
         KIND_HDR: begin
            byte_in = cur_ff.hdr[cnt_ff[3:0]];
            last_in = final_beat && cur_ff.last;
         end
         default: begin
            if (cnt_ff != 5'd0) begin
               byte_in = answer_byte(ans_idx, answer_ttl, answer_ipv4);
            end
            if (final_beat) begin
               last_in  = 1'b1;
               qtype_in = cur_ff.qtype;
            end
         end
      endcase
   end

   // Step through beats and fetch the next command
   always_comb begin
      cur_in  = cur_ff;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (pop) begin
         cur_in  = head;
         busy_in = 1'b1;
         cnt_in  = 5'd0;
      end else if (load && final_beat) begin
         busy_in = 1'b0;
      end else if (load) begin
         cnt_in = cnt_ff + 5'd1;
      end
   end

   // Output stage valid: set on load, clear once transferred
   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         cnt_ff   <= 5'd0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (load) begin
         byte_ff   <= byte_in;
         bvalid_ff <= bvalid_in;
         last_ff   <= last_in;
         status_ff <= status_in;
         qtype_ff  <= qtype_in;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_byte  = byte_ff;
   assign rsp_out_valid = bvalid_ff;
   assign rsp_out_last  = last_ff;
   assign rsp_status    = status_ff;
   assign rsp_qtype     = qtype_ff;

endmodule

`default_nettype wire

[design/dns_a_record_responder_unit.sv]
// DNS A-record responder: front parser, command queue, byte-expanding back end.
// A taken byte's command passes the queue, current-command and output registers.
// Throughput: one query byte per cycle in and one result per cycle out while the
// output is not stalled; the header (12 results) and answer (17 results) bursts
// drain at one per cycle; input stalls once the QUEUE_DEPTH-entry queue is full.
// Reset (synchronous): parse state, queue and output stage clear; registers reload.
`default_nettype none

module dns_a_record_responder_unit
   import dar_pkg::*;
#(
   parameter int MAX_PACKET  = MaxPacketDef,
   parameter int QUEUE_DEPTH = QueueDepthDef
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Query byte channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic        req_in_last,
   // Response channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_out_valid,
   output logic             rsp_out_last,
   output logic [1:0]       rsp_status,
   output logic [15:0]      rsp_qtype,
   // Register port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam logic       REG_IPV4 = 1'b0;
   localparam logic       REG_TTL  = 1'b1;
   localparam logic [31:0] IPV4_RESET = 32'h7F00_0001;
   localparam logic [31:0] TTL_RESET  = 32'd300;

   logic [31:0] ipv4_ff, ipv4_in;
   logic [31:0] ttl_ff, ttl_in;
   logic        cfg_write;

   dar_cmd_type front_cmd;
   logic        front_push;
   dar_cmd_type q_head;
   logic        q_not_empty;
   logic        q_full;
   logic        q_pop;
   logic        accept;

   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Register writes
   always_comb begin
      ipv4_in = ipv4_ff;
      ttl_in  = ttl_ff;
      if (cfg_write) begin
         unique case (csr_paddr[2])
            REG_IPV4: ipv4_in = csr_pwdata;
            REG_TTL:  ttl_in  = csr_pwdata;
            default:  ipv4_in = ipv4_ff;
         endcase
      end
   end

   // Register reads
   always_comb begin
      unique case (csr_paddr[2])
         REG_IPV4: csr_prdata = ipv4_ff;
         REG_TTL:  csr_prdata = ttl_ff;
         default:  csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ipv4_ff <= IPV4_RESET;
         ttl_ff  <= TTL_RESET;
      end else begin
         ipv4_ff <= ipv4_in;
         ttl_ff  <= ttl_in;
      end
   end

   // Hold off input while the queue has no room
   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;

   dar_front #(
      .MAX_PACKET (MAX_PACKET)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_byte (req_in_byte),
      .in_last (req_in_last),
      .cmd     (front_cmd),
      .push    (front_push)
   );

   dar_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_cmd),
      .pop       (q_pop),
      .head      (q_head),
      .not_empty (q_not_empty),
      .full      (q_full)
   );

   dar_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (q_head),
      .head_valid    (q_not_empty),
      .pop           (q_pop),
      .answer_ipv4   (ipv4_ff),
      .answer_ttl    (ttl_ff),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_out_valid (rsp_out_valid),
      .rsp_out_last  (rsp_out_last),
      .rsp_status    (rsp_status),
      .rsp_qtype     (rsp_qtype)
   );

endmodule

`default_nettype wire
